>>> rtl/gost_pkg.sv
// ----------------------------------------------------------------------------
// GOST cipher package
// Shared types and constants for the GOST 28147-89 mode engine.
// ----------------------------------------------------------------------------
package gost_pkg;

  localparam logic [1:0] REQ_DATA    = 2'd0;
  localparam logic [1:0] REQ_ROW     = 2'd1;
  localparam logic [1:0] REQ_SYNC    = 2'd2;
  localparam logic [1:0] REQ_PREPARE = 2'd3;

  localparam logic [2:0] MODE_ECB_ENC = 3'd0;
  localparam logic [2:0] MODE_ECB_DEC = 3'd1;
  localparam logic [2:0] MODE_CTR     = 3'd2;
  localparam logic [2:0] MODE_CFB_ENC = 3'd3;
  localparam logic [2:0] MODE_CFB_DEC = 3'd4;
  localparam logic [2:0] MODE_MAC     = 3'd5;

  localparam logic [2:0] CFG_KEY01   = 3'd0;
  localparam logic [2:0] CFG_KEY23   = 3'd1;
  localparam logic [2:0] CFG_KEY45   = 3'd2;
  localparam logic [2:0] CFG_KEY67   = 3'd3;
  localparam logic [2:0] CFG_MODE    = 3'd4;
  localparam logic [2:0] CFG_SWAP    = 3'd5;
  localparam logic [2:0] CFG_PAD     = 3'd6;

  localparam logic [31:0] GAMMA_C0 = 32'h0101_0101;
  localparam logic [31:0] GAMMA_C1 = 32'h0101_0104;

  // Datapath load selections.
  typedef enum logic [2:0] {
    LD_NONE,
    LD_ECB,
    LD_CTR,
    LD_CHAIN,
    LD_MAC,
    LD_PREP
  } load_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    load_sel_t  load;
    logic       round;
    logic       last;
    logic [2:0] key_idx;
    logic       finish;
    logic       finish_prep;
    logic       finish_nop;
  } ctrl_cmd_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    bswap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [63:0] hswap(input logic [63:0] b, input logic en);
    hswap = en ? {bswap32(b[63:32]), bswap32(b[31:0])} : b;
  endfunction

endpackage

>>> rtl/gost_if.sv
// ----------------------------------------------------------------------------
// GOST stream interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface gost_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] block_in;
  logic [3:0]  byte_count;
  logic [2:0]  row_index;
  modport source (output valid, req_type, block_in, byte_count, row_index, input ready);
  modport sink   (input valid, req_type, block_in, byte_count, row_index, output ready);
endinterface

interface gost_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  logic [3:0]  out_bytes;
  modport source (output valid, block_out, out_bytes, input ready);
  modport sink   (input valid, block_out, out_bytes, output ready);
endinterface

>>> rtl/gost_ctrl.sv
// ----------------------------------------------------------------------------
// GOST controller
// Sequences rounds and key order for one request at a time.
// ----------------------------------------------------------------------------
module gost_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [1:0]          req_type,
  input  logic [3:0]          byte_count,
  input  logic [2:0]          mode,
  input  logic                out_free,
  output logic                busy,
  output gost_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t      state_r;
  logic [5:0]  rnd_r;
  logic [1:0]  kind_r;   // 0 encrypt, 1 decrypt, 2 mac
  logic        prep_r;
  logic        nop_r;
  logic [5:0]  nrounds;
  logic [2:0]  ki;
  logic        is_data, data_ok;

  assign is_data = (req_type == gost_pkg::REQ_DATA);
  assign data_ok = (byte_count != 4'd0) && (mode <= gost_pkg::MODE_MAC);
  assign busy    = (state_r != ST_IDLE);
  assign nrounds = (kind_r == 2'd2) ? 6'd16 : 6'd32;

  // Key schedule index for the current round.
  always_comb begin
    case (kind_r)
      2'd0:    ki = (rnd_r < 6'd24) ? rnd_r[2:0] : ~rnd_r[2:0];
      2'd1:    ki = (rnd_r < 6'd8) ? rnd_r[2:0] : ~rnd_r[2:0];
      default: ki = rnd_r[2:0];
    endcase
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.load = gost_pkg::LD_NONE;
    cmd.key_idx = ki;
    cmd.last = (kind_r != 2'd2) && (rnd_r == 6'd31);
    if (state_r == ST_IDLE && in_fire) begin
      case (req_type)
        gost_pkg::REQ_DATA: begin
          if (data_ok) begin
            case (mode)
              gost_pkg::MODE_ECB_ENC, gost_pkg::MODE_ECB_DEC: cmd.load = gost_pkg::LD_ECB;
              gost_pkg::MODE_CTR: cmd.load = gost_pkg::LD_CTR;
              gost_pkg::MODE_MAC: cmd.load = gost_pkg::LD_MAC;
              default: cmd.load = gost_pkg::LD_CHAIN;
            endcase
          end
        end
        gost_pkg::REQ_PREPARE: cmd.load = gost_pkg::LD_PREP;
        default: cmd.load = gost_pkg::LD_NONE;
      endcase
    end
    if (state_r == ST_RUN) cmd.round = 1'b1;
    if (state_r == ST_DONE && out_free) begin
      cmd.finish      = !prep_r && !nop_r;
      cmd.finish_prep = prep_r;
      cmd.finish_nop  = nop_r;
    end
  end

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      kind_r  <= '0;
      prep_r  <= 1'b0;
      nop_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            rnd_r  <= '0;
            prep_r <= (req_type == gost_pkg::REQ_PREPARE);
            nop_r  <= !(is_data && data_ok) && (req_type != gost_pkg::REQ_PREPARE);
            kind_r <= (mode == gost_pkg::MODE_MAC) ? 2'd2 :
                      (mode == gost_pkg::MODE_ECB_DEC) ? 2'd1 : 2'd0;
            if ((is_data && data_ok) ||
                (req_type == gost_pkg::REQ_PREPARE && mode == gost_pkg::MODE_CTR))
              state_r <= ST_RUN;
            else
              state_r <= ST_DONE;
          end
        end
        ST_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == nrounds - 6'd1) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/gost_dp.sv
// ----------------------------------------------------------------------------
// GOST datapath
// Round registers, substitution table, chain value and result register.
// ----------------------------------------------------------------------------
module gost_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gost_pkg::ctrl_cmd_t cmd,
  input  logic                in_fire,
  input  logic [1:0]          req_type,
  input  logic [63:0]         block_in,
  input  logic [3:0]          byte_count,
  input  logic [2:0]          row_index,
  input  logic [255:0]        key,
  input  logic [2:0]          mode,
  input  logic                swap_en,
  input  logic [7:0]          pad_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [63:0]         block_out,
  output logic [3:0]          out_bytes
);

  logic [63:0] sbox_r [8];
  logic [63:0] chain_r, chain_nxt;
  logic [31:0] n1_r, n2_r;
  logic [63:0] data_r, mask_r;
  logic [3:0]  cnt_r;
  logic [63:0] res_r;
  logic [3:0]  nb_r;
  logic        ov_r;
  logic [3:0]  cnt_c;
  logic [63:0] mask_c, data_c, fill;
  logic [31:0] s, f, rk, fr;
  logic [32:0] n2sum;
  logic [31:0] ctr_n1, ctr_n2;
  logic [63:0] wv, g;

  assign cnt_c  = (byte_count > 4'd8) ? 4'd8 : byte_count;
  always_comb begin
    mask_c = '0;
    for (int i = 0; i < 8; i++)
      if (4'(i) < cnt_c) mask_c[8*i +: 8] = 8'hFF;
  end
  assign data_c = block_in & mask_c;
  assign fill   = {8{pad_byte}};

  // Counter increments.
  assign ctr_n1 = chain_r[31:0] + gost_pkg::GAMMA_C0;
  assign n2sum  = {1'b0, chain_r[63:32]} + {1'b0, gost_pkg::GAMMA_C1};
  assign ctr_n2 = n2sum[31:0] + {31'd0, n2sum[32]};

  // One Feistel round.
  assign rk = key[32*cmd.key_idx +: 32];
  assign s  = n1_r + rk;
  always_comb begin
    f = '0;
    for (int r = 0; r < 8; r++)
      f[4*r +: 4] = sbox_r[r][4*s[4*r +: 4] +: 4];
  end
  assign fr = {f[20:0], f[31:21]} ^ n2_r;

  assign wv = {n2_r, n1_r};
  assign g  = gost_pkg::hswap(wv, swap_en);

  // Chain value update at finish.
  always_comb begin
    chain_nxt = chain_r;
    case (mode)
      gost_pkg::MODE_CFB_ENC:
        chain_nxt = gost_pkg::hswap((((data_r ^ g) & mask_r)) | (g & ~mask_r), swap_en);
      gost_pkg::MODE_CFB_DEC:
        chain_nxt = gost_pkg::hswap((data_r & mask_r) | (g & ~mask_r), swap_en);
      gost_pkg::MODE_MAC: chain_nxt = wv;
      default: chain_nxt = chain_r;
    endcase
  end

  // Table rows, round registers and chain value.
  always_ff @(posedge clk) begin
    if (in_fire && req_type == gost_pkg::REQ_ROW) sbox_r[row_index] <= block_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
      n1_r    <= '0;
      n2_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        data_r <= data_c;
        mask_r <= mask_c;
        cnt_r  <= cnt_c;
      end
      if (in_fire && req_type == gost_pkg::REQ_SYNC) chain_r <= block_in;
      case (cmd.load)
        gost_pkg::LD_ECB: begin
          {n2_r, n1_r} <= gost_pkg::hswap(data_c | (fill & ~mask_c), swap_en);
        end
        gost_pkg::LD_CTR: begin
          chain_r <= {ctr_n2, ctr_n1};
          {n2_r, n1_r} <= {ctr_n2, ctr_n1};
        end
        gost_pkg::LD_CHAIN: {n2_r, n1_r} <= chain_r;
        gost_pkg::LD_MAC:   {n2_r, n1_r} <= chain_r ^ data_c;
        gost_pkg::LD_PREP: begin
          {n2_r, n1_r} <= {chain_r[31:0], chain_r[63:32]};
          chain_r <= {chain_r[31:0], chain_r[63:32]};
        end
        default: ;
      endcase
      if (cmd.round) begin
        if (cmd.last) n2_r <= fr;
        else begin
          n2_r <= n1_r;
          n1_r <= fr;
        end
      end
      if (cmd.finish_prep) begin
        if (mode == gost_pkg::MODE_CTR) chain_r <= wv;
        res_r <= '0;
        nb_r  <= '0;
        ov_r  <= 1'b1;
      end else if (cmd.finish_nop) begin
        res_r <= '0;
        nb_r  <= '0;
        ov_r  <= 1'b1;
      end else if (cmd.finish) begin
        chain_r <= chain_nxt;
        ov_r    <= 1'b1;
        case (mode)
          gost_pkg::MODE_MAC: begin
            res_r <= g;
            nb_r  <= 4'd8;
          end
          gost_pkg::MODE_ECB_ENC, gost_pkg::MODE_ECB_DEC: begin
            res_r <= g & mask_r;
            nb_r  <= cnt_r;
          end
          default: begin
            res_r <= (data_r ^ g) & mask_r;
            nb_r  <= cnt_r;
          end
        endcase
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign block_out = res_r;
  assign out_bytes = nb_r;

endmodule

>>> rtl/gost_block_cipher_modes.sv
// ----------------------------------------------------------------------------
// GOST 28147-89 mode engine
// ECB, counter, CFB and MAC over a loadable substitution table.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_     | sink      | req_type, block_in, byte_count, row_index
// out_    | source    | block_out, out_bytes
// cfg_    | write     | cfg_index, cfg_data (64 bits)
//
// A data block is loaded, run through 32 Feistel rounds (16 in MAC mode) and
// written to the result register; a single Feistel round unit does every round.
// Control requests skip the rounds; counter-mode prepare encrypts the synchro.
// The next request is accepted once the previous result register is free
// to be written; out_ready stalls hold the block. Reset is synchronous.
module gost_block_cipher_modes (
  input  logic        clk,
  input  logic        rst_n,
  gost_in_if.sink     in_ch,
  gost_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [255:0] key_r;
  logic [2:0]   mode_r;
  logic         swap_r;
  logic [7:0]   pad_r;
  logic         busy, in_fire, out_free, out_valid;
  gost_pkg::ctrl_cmd_t cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= gost_pkg::MODE_ECB_ENC;
      swap_r <= 1'b0;
      pad_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gost_pkg::CFG_KEY01: key_r[63:0]    <= cfg_data;
        gost_pkg::CFG_KEY23: key_r[127:64]  <= cfg_data;
        gost_pkg::CFG_KEY45: key_r[191:128] <= cfg_data;
        gost_pkg::CFG_KEY67: key_r[255:192] <= cfg_data;
        gost_pkg::CFG_MODE:  mode_r <= cfg_data[2:0];
        gost_pkg::CFG_SWAP:  swap_r <= cfg_data[0];
        gost_pkg::CFG_PAD:   pad_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && !busy;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  gost_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .req_type(in_ch.req_type),
    .byte_count(in_ch.byte_count), .mode(mode_r), .out_free(out_free),
    .busy(busy), .cmd(cmd)
  );

  gost_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_fire(in_fire),
    .req_type(in_ch.req_type), .block_in(in_ch.block_in),
    .byte_count(in_ch.byte_count), .row_index(in_ch.row_index),
    .key(key_r), .mode(mode_r), .swap_en(swap_r), .pad_byte(pad_r),
    .out_ready(out_ch.ready), .out_valid(out_valid),
    .block_out(out_ch.block_out), .out_bytes(out_ch.out_bytes)
  );

endmodule

>>> rtl/gost_checker.sv
// ----------------------------------------------------------------------------
// GOST port checker
// Port-level properties of the mode engine.
// ----------------------------------------------------------------------------
module gost_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_bytes
);

  // A result is never shown with more than eight bytes.
  a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes <= 4'd8) else $error("out_bytes above eight");

  // A request is not taken in the cycle right after another.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("back-to-back accept");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind gost_block_cipher_modes gost_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_bytes(out_ch.out_bytes)
);

>>> verif/gost_tb_if_note.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GOST testbench helper types
// Request and result records shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package gost_tb_pkg;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] block_in;
    logic [3:0]  byte_count;
    logic [2:0]  row_index;
  } gost_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [63:0] block_out;
    logic [3:0]  out_bytes;
  } gost_res_t;

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GOST mode engine testbench
// Drives table loads, synchro and prepare requests and data blocks through all six
// modes and the unused codes 6 and 7, with random idling on both channels, and checks
// every result against a cycle-free cipher predictor kept in step with the registers.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  gost_in_if  in_ch ();
  gost_out_if out_ch ();

  gost_block_cipher_modes dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of the registers and cipher state.
  logic [63:0] key_q [4];
  logic [2:0]  mode_q;
  logic        swap_q;
  logic [7:0]  pad_q;
  logic [63:0] sbox_q [8];
  logic [63:0] chain_q;

  gost_tb_pkg::gost_res_t expected_q [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          recv_hold = 1'b0;
  int          quiet_cycles = 0;

  function automatic logic [63:0] opt_swap(input logic [63:0] b);
    return swap_q ? {b[39:32], b[47:40], b[55:48], b[63:56],
                     b[7:0], b[15:8], b[23:16], b[31:24]} : b;
  endfunction

  // Full Feistel cycle: kind 0 encrypt, 1 decrypt, 2 sixteen-round MAC.
  function automatic logic [63:0] gost_cycle(input logic [63:0] blk, input int kind);
    logic [31:0] n1, n2, s, f, k;
    int          rounds, ki, nib;
    n1 = blk[31:0];
    n2 = blk[63:32];
    rounds = (kind == 2) ? 16 : 32;
    for (int i = 0; i < rounds; i++) begin
      if (kind == 0) ki = (i < 24) ? (i % 8) : (7 - (i % 8));
      else if (kind == 1) ki = (i < 8) ? i : (7 - (i % 8));
      else ki = i % 8;
      k = key_q[ki / 2][32 * (ki % 2) +: 32];
      s = n1 + k;
      f = '0;
      for (int r = 0; r < 8; r++) begin
        nib = s[4*r +: 4];
        f[4*r +: 4] = sbox_q[r][4*nib +: 4];
      end
      f = {f[20:0], f[31:21]} ^ n2;
      if (kind != 2 && i == 31) begin
        n2 = f;
      end else begin
        n2 = n1;
        n1 = f;
      end
    end
    return {n2, n1};
  endfunction

  // Works out the result of one request and advances the predictor state.
  function automatic gost_tb_pkg::gost_res_t predict_cipher(input gost_tb_pkg::gost_req_t rq);
    gost_tb_pkg::gost_res_t r;
    logic [63:0] mask, data, g, fb;
    logic [31:0] n1, n2;
    int          cnt;
    r = '0;
    cnt = (rq.byte_count > 8) ? 8 : rq.byte_count;
    mask = (cnt >= 8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
    data = rq.block_in & mask;
    case (rq.req_type)
      gost_pkg::REQ_ROW: sbox_q[rq.row_index] = rq.block_in;
      gost_pkg::REQ_SYNC: chain_q = rq.block_in;
      gost_pkg::REQ_PREPARE: begin
        chain_q = {chain_q[31:0], chain_q[63:32]};
        if (mode_q == gost_pkg::MODE_CTR) chain_q = gost_cycle(chain_q, 0);
      end
      default: begin
        if (cnt != 0) begin
          case (mode_q)
            gost_pkg::MODE_ECB_ENC, gost_pkg::MODE_ECB_DEC: begin
              g = opt_swap(data | ({8{pad_q}} & ~mask));
              r.block_out = opt_swap(gost_cycle(g, (mode_q == gost_pkg::MODE_ECB_DEC) ? 1 : 0))
                            & mask;
              r.out_bytes = 4'(cnt);
            end
            gost_pkg::MODE_CTR: begin
              n1 = chain_q[31:0] + gost_pkg::GAMMA_C0;
              n2 = chain_q[63:32] + gost_pkg::GAMMA_C1;
              if (n2 < chain_q[63:32]) n2 = n2 + 32'd1;
              chain_q = {n2, n1};
              r.block_out = (data ^ opt_swap(gost_cycle(chain_q, 0))) & mask;
              r.out_bytes = 4'(cnt);
            end
            gost_pkg::MODE_CFB_ENC, gost_pkg::MODE_CFB_DEC: begin
              g = opt_swap(gost_cycle(chain_q, 0));
              r.block_out = (data ^ g) & mask;
              fb = (mode_q == gost_pkg::MODE_CFB_ENC) ? r.block_out : data;
              chain_q = opt_swap((fb & mask) | (g & ~mask));
              r.out_bytes = 4'(cnt);
            end
            gost_pkg::MODE_MAC: begin
              chain_q = gost_cycle(chain_q ^ data, 2);
              r.block_out = opt_swap(chain_q);
              r.out_bytes = 4'd8;
            end
            default: ;
          endcase
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
  endtask

  // Configuration write, mirrored into the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      gost_pkg::CFG_KEY01, gost_pkg::CFG_KEY23,
      gost_pkg::CFG_KEY45, gost_pkg::CFG_KEY67: key_q[idx[1:0]] = val;
      gost_pkg::CFG_MODE: mode_q = val[2:0];
      gost_pkg::CFG_SWAP: swap_q = val[0];
      gost_pkg::CFG_PAD: pad_q = val[7:0];
      default: ;
    endcase
  endtask

  // Sends one request; the expected result is queued at acceptance.
  // Valid stays high after acceptance until the next request or an idle cycle.
  task automatic send_request(input gost_tb_pkg::gost_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rq.req_type;
    in_ch.block_in   <= rq.block_in;
    in_ch.byte_count <= rq.byte_count;
    in_ch.row_index  <= rq.row_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_cipher(rq));
  endtask

  // Waits for the block to drain before a register write.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic gost_tb_pkg::gost_req_t random_request();
    gost_tb_pkg::gost_req_t rq;
    int        pick;
    pick = $urandom_range(99);
    rq.block_in   = {$urandom, $urandom};
    rq.row_index  = 3'($urandom_range(7));
    rq.byte_count = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
    if (pick < 85) rq.req_type = gost_pkg::REQ_DATA;
    else if (pick < 92) rq.req_type = gost_pkg::REQ_SYNC;
    else if (pick < 97) rq.req_type = gost_pkg::REQ_PREPARE;
    else rq.req_type = gost_pkg::REQ_ROW;
    return rq;
  endfunction

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    gost_tb_pkg::gost_res_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_ch.block_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.block_out !== want.block_out)
            report_mismatch("block_out", out_ch.block_out, want.block_out);
          if (out_ch.out_bytes !== want.out_bytes)
            report_mismatch("out_bytes", 64'(out_ch.out_bytes), 64'(want.out_bytes));
        end
      end
    end
  end

  // Directed rows: table load first, then extremes and special cases.
  gost_tb_pkg::gost_req_t directed_rows [20];
  logic [63:0] directed_want [20];
  bit          directed_known [20];

  initial begin
    gost_tb_pkg::gost_req_t rq;
    gost_tb_pkg::gost_res_t got_want;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = gost_pkg::REQ_DATA;
    in_ch.block_in   = '0;
    in_ch.byte_count = 4'd8;
    in_ch.row_index  = '0;
    foreach (key_q[i]) key_q[i] = '0;
    foreach (sbox_q[i]) sbox_q[i] = '0;
    mode_q = gost_pkg::MODE_ECB_ENC;
    swap_q = 1'b0;
    pad_q = '0;
    chain_q = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keys and mode at their extremes first.
    write_reg(gost_pkg::CFG_KEY01, '1);
    write_reg(gost_pkg::CFG_KEY23, '0);
    write_reg(gost_pkg::CFG_KEY45, 64'h0123_4567_89ab_cdef);
    write_reg(gost_pkg::CFG_KEY67, '1);
    write_reg(gost_pkg::CFG_MODE, 64'(gost_pkg::MODE_ECB_ENC));
    write_reg(gost_pkg::CFG_SWAP, 64'd0);
    write_reg(gost_pkg::CFG_PAD, 64'hff);

    for (int i = 0; i < 8; i++)
      directed_rows[i] = '{gost_pkg::REQ_ROW, {$urandom, $urandom}, 4'd8, i[2:0]};
    directed_rows[8]  = '{gost_pkg::REQ_DATA, '0, 4'd8, 3'd0};
    directed_rows[9]  = '{gost_pkg::REQ_DATA, '1, 4'd8, 3'd7};
    directed_rows[10] = '{gost_pkg::REQ_DATA, '1, 4'd1, 3'd0};
    directed_rows[11] = '{gost_pkg::REQ_DATA, 64'h8000_0000_0000_0001, 4'd7, 3'd0};
    directed_rows[12] = '{gost_pkg::REQ_DATA, '1, 4'd0, 3'd0};
    directed_rows[13] = '{gost_pkg::REQ_DATA, '1, 4'd15, 3'd0};
    directed_rows[14] = '{gost_pkg::REQ_SYNC, '1, 4'd8, 3'd0};
    directed_rows[15] = '{gost_pkg::REQ_PREPARE, '0, 4'd8, 3'd0};
    directed_rows[16] = '{gost_pkg::REQ_SYNC, '0, 4'd0, 3'd0};
    directed_rows[17] = '{gost_pkg::REQ_DATA, 64'h5555_aaaa_5555_aaaa, 4'd9, 3'd0};
    directed_rows[18] = '{gost_pkg::REQ_ROW, '1, 4'd8, 3'd7};
    directed_rows[19] = '{gost_pkg::REQ_DATA, 64'h0, 4'd4, 3'd0};
    for (int i = 0; i < 20; i++) begin
      directed_known[i] = (directed_rows[i].req_type != gost_pkg::REQ_DATA) ||
                          (directed_rows[i].byte_count == 0);
      directed_want[i]  = '0;
    end

    send_idle_pct = 9;
    recv_idle_pct = 71;
    for (int i = 0; i < 20; i++) begin
      if (directed_known[i]) begin
        // Control and empty items read off directly: zero result.
        got_want = '{directed_want[i], 4'd0};
        send_request(directed_rows[i]);
        if (expected_q[$] !== got_want)
          report_mismatch("directed prediction", expected_q[$].block_out,
                          got_want.block_out);
      end else begin
        send_request(directed_rows[i]);
      end
    end

    // Random phases across every mode and both swap settings.
    for (int ph = 0; ph < 24; ph++) begin
      drain_block();
      write_reg(gost_pkg::CFG_MODE, 64'((ph % 8 == 7) ? 6 + (ph / 8) % 2 : ph % 6));
      write_reg(gost_pkg::CFG_SWAP, 64'((ph / 6) % 2));
      write_reg(gost_pkg::CFG_PAD, (ph % 3 == 0) ? 64'h00 : 64'($urandom_range(255)));
      write_reg(3'(ph % 4), (ph % 5 == 0) ? '1 : {$urandom, $urandom});
      if (ph == 8) begin
        send_idle_pct = 71;
        recv_idle_pct = 9;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 20) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      rq = '{gost_pkg::REQ_SYNC, {$urandom, $urandom}, 4'd8, 3'd0};
      send_request(rq);
      if (ph % 2 == 1) begin
        rq.req_type = gost_pkg::REQ_PREPARE;
        send_request(rq);
      end
      for (int n = 0; n < 62; n++) send_request(random_request());
    end

    drain_block();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
